FILE: rtl/rng_monobit_poker_health_test_assert.svh
// Assertion helpers for the health test. Both macros sample on clk and are
// disabled while rst is high.
`ifndef RNG_MONOBIT_POKER_HEALTH_TEST_ASSERT_SVH
`define RNG_MONOBIT_POKER_HEALTH_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define RMPH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RMPH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RMPH_ASSERT_SAME(label, ante, cons, msg)
`define RMPH_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/rmph_pkg.sv
package rmph_pkg;

  // Bytes per test block.
  localparam int BLOCK_BYTES = 1024;

  localparam int BYTE_W       = 8;
  localparam int NIB_W        = 4;
  localparam int NIB_VALUES   = 16;
  localparam int ONES_W       = 14;
  localparam int POKER_W      = 26;
  localparam int VERDICT_W    = 2;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 26;
  localparam int POPCNT_W     = 4;

  localparam int BYTE_CNT_W   = $clog2(BLOCK_BYTES);
  localparam int NIB_CNT_W    = $clog2(2 * BLOCK_BYTES + 1);
  localparam int SUMSQ_W      = $clog2(4 * BLOCK_BYTES * BLOCK_BYTES + 1);
  localparam int POKER_CALC_W = 27;

  // k*k with k = 2*BLOCK_BYTES nibbles per block.
  localparam logic [POKER_CALC_W-1:0] POKER_OFFSET =
    POKER_CALC_W'(4 * BLOCK_BYTES * BLOCK_BYTES);
  localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(BLOCK_BYTES - 1);

  localparam logic [ONES_W-1:0]  MONOBIT_MIN_RST = ONES_W'(3687);
  localparam logic [ONES_W-1:0]  MONOBIT_MAX_RST = ONES_W'(4505);
  localparam logic [POKER_W-1:0] POKER_MIN_RST   = POKER_W'(4424);
  localparam logic [POKER_W-1:0] POKER_MAX_RST   = POKER_W'(94556);

  typedef logic [NIB_CNT_W-1:0] nib_cnt_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_PASS    = 2'd0,
    VERDICT_MONOBIT = 2'd1,
    VERDICT_POKER   = 2'd2
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MONOBIT_MIN = 4'd0,
    CFG_MONOBIT_MAX = 4'd1,
    CFG_POKER_MIN   = 4'd2,
    CFG_POKER_MAX   = 4'd3
  } cfg_reg_t;

endpackage

FILE: rtl/rmph_if.sv
interface rmph_sample_if import rmph_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] sample_byte;

  modport source (output valid, output sample_byte, input ready);
  modport sink   (input valid, input sample_byte, output ready);
endinterface

interface rmph_result_if import rmph_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [ONES_W-1:0]    ones_total;
  logic [POKER_W-1:0]   poker_value;

  modport source (output valid, output verdict, output ones_total, output poker_value,
                  input ready);
  modport sink   (input valid, input verdict, input ones_total, input poker_value,
                  output ready);
endinterface

interface rmph_cfg_if import rmph_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/rng_monobit_poker_health_test.sv
// Throughput: one sample word per cycle, but a block's last word waits while the
// finished-totals register cannot drain; one result word per BLOCK_BYTES words.
// Result path: input register, counter stage, totals register, result register.
// Reset (rst, synchronous): all counts clear, bounds return to their defaults,
// and the block is ready for samples in the first cycle after reset.
`include "rng_monobit_poker_health_test_assert.svh"

module rng_monobit_poker_health_test import rmph_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  rmph_sample_if.sink     sample,
  rmph_result_if.source   result,
  rmph_cfg_if.sink        cfg
);

  // ---------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes are
  // dropped and each register keeps only its own width of data.
  // ---------------------------------------------------------------------
  logic [ONES_W-1:0]  monobit_min;
  logic [ONES_W-1:0]  monobit_max;
  logic [POKER_W-1:0] poker_min;
  logic [POKER_W-1:0] poker_max;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      monobit_min <= MONOBIT_MIN_RST;
      monobit_max <= MONOBIT_MAX_RST;
      poker_min   <= POKER_MIN_RST;
      poker_max   <= POKER_MAX_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MONOBIT_MIN: monobit_min <= cfg.data[ONES_W-1:0];
        CFG_MONOBIT_MAX: monobit_max <= cfg.data[ONES_W-1:0];
        CFG_POKER_MIN:   poker_min   <= cfg.data[POKER_W-1:0];
        CFG_POKER_MAX:   poker_max   <= cfg.data[POKER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control. Each stage moves on when the stage after it has room, so
  // a finished result waiting in the output register does not stop the
  // counters; only the end of a further block has to wait for it.
  // ---------------------------------------------------------------------
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              done_valid;
  logic              out_valid;
  logic [BYTE_CNT_W-1:0] bytes_seen;

  logic out_free;
  logic done_free;
  logic last_byte;
  logic consume;

  assign out_free  = !out_valid || result.ready;
  assign done_free = !done_valid || out_free;
  assign last_byte = (bytes_seen == LAST_BYTE);
  assign consume   = in_valid && (!last_byte || done_free);
  assign sample.ready = !in_valid || consume;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      in_byte <= sample.sample_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Counter stage. Sixteen nibble counters work as lanes: each one adds the
  // number of nibbles of the current word that match its value. The square
  // sum grows by 2c+1 per hit; when both nibbles hit the same counter the
  // two steps fold into 4c+4.
  // ---------------------------------------------------------------------
  logic [ONES_W-1:0]  ones_count;
  logic [SUMSQ_W-1:0] square_sum;
  nib_cnt_t           nibble_counts [NIB_VALUES];

  logic [NIB_W-1:0]    nib_lo;
  logic [NIB_W-1:0]    nib_hi;
  nib_cnt_t            cnt_lo;
  nib_cnt_t            cnt_hi;
  logic [SUMSQ_W-1:0]  sq_delta;
  logic [ONES_W-1:0]   ones_next;
  logic [SUMSQ_W-1:0]  square_sum_next;
  logic [POPCNT_W-1:0] byte_ones;

  assign nib_lo    = in_byte[NIB_W-1:0];
  assign nib_hi    = in_byte[BYTE_W-1:NIB_W];
  assign byte_ones = POPCNT_W'($countones(in_byte));

  always_comb begin
    cnt_lo = '0;
    cnt_hi = '0;
    for (int i = 0; i < NIB_VALUES; i++) begin
      if (nib_lo == NIB_W'(i)) begin
        cnt_lo = cnt_lo | nibble_counts[i];
      end
      if (nib_hi == NIB_W'(i)) begin
        cnt_hi = cnt_hi | nibble_counts[i];
      end
    end
  end

  always_comb begin
    if (nib_lo == nib_hi) begin
      sq_delta = (SUMSQ_W'(cnt_lo) << 2) + SUMSQ_W'(4);
    end else begin
      sq_delta = ((SUMSQ_W'(cnt_lo) + SUMSQ_W'(cnt_hi)) << 1) + SUMSQ_W'(2);
    end
  end

  assign ones_next       = ones_count + ONES_W'(byte_ones);
  assign square_sum_next = square_sum + sq_delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      ones_count <= '0;
      square_sum <= '0;
      for (int i = 0; i < NIB_VALUES; i++) begin
        nibble_counts[i] <= '0;
      end
    end else if (consume) begin
      if (last_byte) begin
        bytes_seen <= '0;
        ones_count <= '0;
        square_sum <= '0;
        for (int i = 0; i < NIB_VALUES; i++) begin
          nibble_counts[i] <= '0;
        end
      end else begin
        bytes_seen <= bytes_seen + BYTE_CNT_W'(1);
        ones_count <= ones_next;
        square_sum <= square_sum_next;
        for (int i = 0; i < NIB_VALUES; i++) begin
          nibble_counts[i] <= nibble_counts[i]
                              + NIB_CNT_W'(nib_lo == NIB_W'(i))
                              + NIB_CNT_W'(nib_hi == NIB_W'(i));
        end
      end
    end
  end

  // Finished block totals, held until the result register takes them.
  logic [ONES_W-1:0]  ones_done;
  logic [SUMSQ_W-1:0] square_sum_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      done_valid <= 1'b0;
    end else if (consume && last_byte) begin
      done_valid <= 1'b1;
    end else if (out_free) begin
      done_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && last_byte) begin
      ones_done       <= ones_next;
      square_sum_done <= square_sum_next;
    end
  end

  // ---------------------------------------------------------------------
  // Verdict stage. The poker value 16*sumsq - k*k is exact and never
  // negative. A monobit failure outranks a poker failure.
  // ---------------------------------------------------------------------
  logic [POKER_CALC_W-1:0] poker_wide;
  logic [POKER_W-1:0]      poker_calc;
  verdict_t                verdict_calc;

  assign poker_wide = POKER_CALC_W'({square_sum_done, 4'b0000}) - POKER_OFFSET;
  assign poker_calc = poker_wide[POKER_W-1:0];

  always_comb begin
    if (ones_done < monobit_min || ones_done > monobit_max) begin
      verdict_calc = VERDICT_MONOBIT;
    end else if (poker_calc < poker_min || poker_calc > poker_max) begin
      verdict_calc = VERDICT_POKER;
    end else begin
      verdict_calc = VERDICT_PASS;
    end
  end

  logic [VERDICT_W-1:0] verdict_q;
  logic [ONES_W-1:0]    ones_q;
  logic [POKER_W-1:0]   poker_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && done_valid) begin
      verdict_q <= verdict_calc;
      ones_q    <= ones_done;
      poker_q   <= poker_calc;
    end
  end

  assign result.valid       = out_valid;
  assign result.verdict     = verdict_q;
  assign result.ones_total  = ones_q;
  assign result.poker_value = poker_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `RMPH_ASSERT_SAME(a_empty_block_clear, bytes_seen == '0,
                    ones_count == '0 && square_sum == '0, "counts not clear at block start")
  `RMPH_ASSERT_NEXT(a_block_end_restart, consume && last_byte,
                    bytes_seen == '0 && done_valid, "block end did not restart the counts")
  `RMPH_ASSERT_SAME(a_stall_cause, in_valid && !consume,
                    last_byte && done_valid && !out_free, "input stalled without a full result")
  `RMPH_ASSERT_NEXT(a_done_drains, done_valid && out_free,
                    out_valid, "finished totals did not reach the result register")

endmodule
